// ===== src/vpa_pkg.sv =====
// Package with the shared types and constants of the variable partition allocator.
`timescale 1ns / 1ps
package vpa_pkg;

  localparam int TABLE_DEPTH = 32;
  localparam int ADDR_BITS   = 16;
  localparam int TAG_BITS    = 8;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

  typedef struct packed {
    logic [ADDR_BITS-1:0] start;
    logic [ADDR_BITS-1:0] len;
    logic [TAG_BITS-1:0]  owner;
    logic                 hole;
  } seg_t;

  typedef enum logic [2:0] {
    C_HOLD,
    C_FROM_LOW,
    C_FROM_HIGH,
    C_WR_A,
    C_WR_B
  } cell_op_e;

  typedef enum logic [1:0] {
    K_ALLOC   = 2'd0,
    K_FREE    = 2'd1,
    K_COMPACT = 2'd2,
    K_DEFINE  = 2'd3
  } kind_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_NOFIT   = 3'd1,
    ST_NOTAG   = 3'd2,
    ST_FULL    = 3'd3,
    ST_BADPART = 3'd4
  } status_e;

  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  typedef enum logic [3:0] {
    S_IDLE,
    S_START,
    S_SCAN,
    S_DECIDE,
    S_SHIFT,
    S_SUM,
    S_CHECK,
    S_COLLAPSE,
    S_PLACE
  } state_e;

endpackage

// ===== src/vpa_cell.sv =====
// One segment cell of the table, loading from a neighbor or a write bus.
`timescale 1ns / 1ps
module vpa_cell
  import vpa_pkg::*;
(
  input  logic     clk_i,
  input  cell_op_e op_i,
  input  seg_t     low_i,
  input  seg_t     high_i,
  input  seg_t     wr_a_i,
  input  seg_t     wr_b_i,
  output seg_t     seg_o
);

  seg_t seg_q, seg_d;

  always_comb begin
    case (op_i)
      C_FROM_LOW:  seg_d = low_i;
      C_FROM_HIGH: seg_d = high_i;
      C_WR_A:      seg_d = wr_a_i;
      C_WR_B:      seg_d = wr_b_i;
      default:     seg_d = seg_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    seg_q <= seg_d;
  end

  assign seg_o = seg_q;

endmodule

// ===== src/variable_partition_allocator.sv =====
// Top level of the variable partition allocator: controller and row of segment cells.
//
//  channel   direction  payload
//  s_axis    in         tuser kind, tdata tag/size/partition bounds
//  m_axis    out        tdata status and block address
//  cfg       in         cfg_data_i allocation policy
//
// Allocate and free scan the table one cell per cycle; allocate passes through one more
// state that shifts the table up when a hole is split. Compact makes a sum pass, then
// removes holes one hole per cycle, then makes an address pass. Define is decided in the
// start state.
// The table needs no clearing after reset; only the state, policy, entry count and output valid are reset.
// A new request is taken only after the previous result has been taken.
`timescale 1ns / 1ps
module variable_partition_allocator
  import vpa_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // proc_tag, req_size, part_start, part_end
  input  logic [1:0]  s_axis_tuser,   // kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // status, block_addr, zero fill
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_data_i
);

  state_e state_q, state_d;
  logic [1:0] pol_q;
  logic [CNT_W-1:0] cnt_q, cnt_d, k_q, k_d, blocks_q, blocks_d;
  logic [IDX_W-1:0] pick_q, pick_d;
  logic found_q, found_d;
  logic [ADDR_BITS-1:0] pick_len_q, pick_len_d, pick_start_q, pick_start_d;
  logic [ADDR_BITS-1:0] base_q, base_d;
  logic [ADDR_BITS:0] pos_q, pos_d, top_q, top_d;
  kind_e kind_q;
  logic [TAG_BITS-1:0] tag_q;
  logic [ADDR_BITS-1:0] size_q, pst_q, pend_q;
  logic out_v_q, out_v_d;
  status_e out_st_q, out_st_d;
  logic [ADDR_BITS-1:0] out_addr_q, out_addr_d;

  seg_t seg [TABLE_DEPTH];
  cell_op_e op [TABLE_DEPTH];
  seg_t wr_a, wr_b, rd;
  logic [IDX_W-1:0] rd_idx, wa_idx, wb_idx, h_idx;
  logic wa_en, wb_en, up_en, dn_en, h_found, cond, first_pol;
  logic [ADDR_BITS:0] last_end;
  logic s_acc;

  assign s_acc         = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE) && !out_v_q;
  assign cfg_ready_o   = 1'b1;
  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = {5'd0, out_addr_q, out_st_q};

  assign rd       = seg[rd_idx];
  assign last_end = {1'b0, rd.start} + {1'b0, rd.len};
  assign first_pol = (pol_q != POL_BEST) && (pol_q != POL_WORST);

  always_comb begin
    h_found = 1'b0;
    h_idx   = '0;
    for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
      if (CNT_W'(i) < cnt_q && seg[i].hole) begin
        h_found = 1'b1;
        h_idx   = IDX_W'(i);
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    cnt_d        = cnt_q;
    k_d          = k_q;
    blocks_d     = blocks_q;
    pick_d       = pick_q;
    found_d      = found_q;
    pick_len_d   = pick_len_q;
    pick_start_d = pick_start_q;
    base_d       = base_q;
    pos_d        = pos_q;
    top_d        = top_q;
    out_v_d      = out_v_q && !m_axis_tready;
    out_st_d     = out_st_q;
    out_addr_d   = out_addr_q;
    rd_idx       = k_q[IDX_W-1:0];
    wa_en        = 1'b0;
    wb_en        = 1'b0;
    up_en        = 1'b0;
    dn_en        = 1'b0;
    wa_idx       = k_q[IDX_W-1:0];
    wb_idx       = pick_q + IDX_W'(1);
    wr_a         = '{start: pick_start_q, len: size_q, owner: tag_q, hole: 1'b0};
    wr_b         = '{start: pick_start_q + size_q, len: pick_len_q - size_q,
                     owner: '0, hole: 1'b1};
    cond         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (s_acc) begin
          k_d      = '0;
          found_d  = 1'b0;
          blocks_d = '0;
          state_d  = S_START;
        end
      end
      S_START: begin
        rd_idx = (kind_q == K_DEFINE) ? IDX_W'(cnt_q - CNT_W'(1)) : '0;
        unique case (kind_q)
          K_ALLOC: begin
            if (size_q == '0) begin
              out_v_d = 1'b1; out_st_d = ST_NOFIT; out_addr_d = '0; state_d = S_IDLE;
            end else begin
              state_d = S_SCAN;
            end
          end
          K_FREE: state_d = S_SCAN;
          K_COMPACT: begin
            if (cnt_q == '0) begin
              out_v_d = 1'b1; out_st_d = ST_OK; out_addr_d = '0; state_d = S_IDLE;
            end else begin
              base_d  = rd.start;
              pos_d   = {1'b0, rd.start};
              state_d = S_SUM;
            end
          end
          default: begin
            out_v_d    = 1'b1;
            out_addr_d = '0;
            state_d    = S_IDLE;
            if (pend_q <= pst_q || (cnt_q != '0 && {1'b0, pst_q} < last_end)) begin
              out_st_d = ST_BADPART;
            end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
              out_st_d = ST_FULL;
            end else begin
              out_st_d = ST_OK;
              wa_en    = 1'b1;
              wa_idx   = cnt_q[IDX_W-1:0];
              wr_a     = '{start: pst_q, len: pend_q - pst_q, owner: '0, hole: 1'b1};
              cnt_d    = cnt_q + CNT_W'(1);
            end
          end
        endcase
      end
      S_SCAN: begin
        if (k_q == cnt_q) begin
          if (kind_q == K_FREE) begin
            out_v_d = 1'b1; out_st_d = ST_NOTAG; out_addr_d = '0; state_d = S_IDLE;
          end else begin
            state_d = S_DECIDE;
          end
        end else if (kind_q == K_FREE) begin
          k_d = k_q + CNT_W'(1);
          if (!rd.hole && rd.owner == tag_q) begin
            wa_en      = 1'b1;
            wr_a       = '{start: rd.start, len: rd.len, owner: '0, hole: 1'b1};
            out_v_d    = 1'b1;
            out_st_d   = ST_OK;
            out_addr_d = rd.start;
            state_d    = S_IDLE;
          end
        end else begin
          k_d  = k_q + CNT_W'(1);
          cond = rd.hole && rd.len >= size_q;
          if (cond && (!found_q || (pol_q == POL_BEST && rd.len < pick_len_q) ||
                       (pol_q == POL_WORST && rd.len > pick_len_q))) begin
            found_d      = 1'b1;
            pick_d       = k_q[IDX_W-1:0];
            pick_len_d   = rd.len;
            pick_start_d = rd.start;
          end
          if (cond && first_pol) state_d = S_DECIDE;
        end
      end
      S_DECIDE: begin
        out_addr_d = '0;
        state_d    = S_IDLE;
        out_v_d    = 1'b1;
        if (!found_q) begin
          out_st_d = ST_NOFIT;
        end else if (pick_len_q == size_q) begin
          wa_en      = 1'b1;
          wa_idx     = pick_q;
          out_st_d   = ST_OK;
          out_addr_d = pick_start_q;
        end else if (cnt_q == CNT_W'(TABLE_DEPTH)) begin
          out_st_d = ST_FULL;
        end else begin
          out_v_d = 1'b0;
          state_d = S_SHIFT;
        end
      end
      S_SHIFT: begin
        wa_en      = 1'b1;
        wa_idx     = pick_q;
        wb_en      = 1'b1;
        up_en      = 1'b1;
        cnt_d      = cnt_q + CNT_W'(1);
        out_v_d    = 1'b1;
        out_st_d   = ST_OK;
        out_addr_d = pick_start_q;
        state_d    = S_IDLE;
      end
      S_SUM: begin
        k_d = k_q + CNT_W'(1);
        if (!rd.hole) begin
          blocks_d = blocks_q + CNT_W'(1);
          pos_d    = pos_q + {1'b0, rd.len};
        end
        if (k_q == cnt_q - CNT_W'(1)) begin
          top_d   = last_end;
          state_d = S_CHECK;
        end
      end
      S_CHECK: begin
        if (top_q > pos_q && blocks_q == CNT_W'(TABLE_DEPTH)) begin
          out_v_d = 1'b1; out_st_d = ST_FULL; out_addr_d = '0; state_d = S_IDLE;
        end else begin
          state_d = S_COLLAPSE;
        end
      end
      S_COLLAPSE: begin
        if (h_found) begin
          dn_en = 1'b1;
          cnt_d = cnt_q - CNT_W'(1);
        end else begin
          k_d     = '0;
          pos_d   = {1'b0, base_q};
          state_d = S_PLACE;
        end
      end
      S_PLACE: begin
        if (k_q == cnt_q) begin
          if (top_q > pos_q) begin
            wa_en = 1'b1;
            wr_a  = '{start: pos_q[ADDR_BITS-1:0],
                      len: ADDR_BITS'(top_q - pos_q), owner: '0, hole: 1'b1};
            cnt_d = cnt_q + CNT_W'(1);
          end
          out_v_d = 1'b1; out_st_d = ST_OK; out_addr_d = '0; state_d = S_IDLE;
        end else begin
          wa_en = 1'b1;
          wr_a  = '{start: pos_q[ADDR_BITS-1:0], len: rd.len, owner: rd.owner, hole: 1'b0};
          pos_d = pos_q + {1'b0, rd.len};
          k_d   = k_q + CNT_W'(1);
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    for (int i = 0; i < TABLE_DEPTH; i++) begin
      if (wa_en && IDX_W'(i) == wa_idx) begin
        op[i] = C_WR_A;
      end else if (wb_en && IDX_W'(i) == wb_idx) begin
        op[i] = C_WR_B;
      end else if (up_en && CNT_W'(i) > CNT_W'(pick_q) + CNT_W'(1) && CNT_W'(i) <= cnt_q) begin
        op[i] = C_FROM_LOW;
      end else if (dn_en && IDX_W'(i) >= h_idx) begin
        op[i] = C_FROM_HIGH;
      end else begin
        op[i] = C_HOLD;
      end
    end
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    vpa_cell u_cell (
      .clk_i  (clk_i),
      .op_i   (op[g]),
      .low_i  (seg[(g == 0) ? 0 : g - 1]),
      .high_i (seg[(g == TABLE_DEPTH - 1) ? g : g + 1]),
      .wr_a_i (wr_a),
      .wr_b_i (wr_b),
      .seg_o  (seg[g])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      pol_q   <= '0;
      cnt_q   <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      out_v_q <= out_v_d;
      if (cfg_valid_i) pol_q <= cfg_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    k_q          <= k_d;
    blocks_q     <= blocks_d;
    pick_q       <= pick_d;
    found_q      <= found_d;
    pick_len_q   <= pick_len_d;
    pick_start_q <= pick_start_d;
    base_q       <= base_d;
    pos_q        <= pos_d;
    top_q        <= top_d;
    out_st_q     <= out_st_d;
    out_addr_q   <= out_addr_d;
    if (s_acc) begin
      kind_q <= kind_e'(s_axis_tuser);
      tag_q  <= s_axis_tdata[7:0];
      size_q <= s_axis_tdata[23:8];
      pst_q  <= s_axis_tdata[39:24];
      pend_q <= s_axis_tdata[55:40];
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(TABLE_DEPTH))
    else $error("segment count beyond table depth");

  a_err_addr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[2:0] != ST_OK) |-> m_axis_tdata[18:3] == '0)
    else $error("failed request with nonzero address");

  a_one_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> !s_axis_tready)
    else $error("request taken while busy");

endmodule
